[src/constant_power_stereo_pan_core_assert.svh]
// ----------------------------------------------------------------------------
// constant power stereo pan core assertion macros
// shared property wrappers, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef CONSTANT_POWER_STEREO_PAN_CORE_ASSERT_SVH
`define CONSTANT_POWER_STEREO_PAN_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define CPSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define CPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cpsp_pkg.sv]
// ----------------------------------------------------------------------------
// cpsp_pkg
// constants, register codes and the quarter-sine gain function for the pan core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpsp_pkg;

  localparam int unsigned GainFracBitsDefault = 16;
  // table covers pan positions 0..PanSteps after offsetting by PanOffset
  localparam int unsigned PanSteps            = 200;
  localparam int signed   PanOffset           = 100;

  localparam logic [63:0]        PiQ30  = 64'd3373259426;
  localparam logic signed [63:0] OneQ30 = 64'sd1073741824;

  // (2n)*(2n+1) for the taylor terms n = 1..12
  localparam logic [63:0] SeriesDiv [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef enum logic {
    RegPan      = 1'b0,
    RegChannels = 1'b1
  } cpsp_reg_e;

  // sin(k*pi/400) as Q1.frac, Taylor series in Q2.30, rounded half up
  function automatic logic [63:0] cpsp_quarter_sine(input int unsigned k,
                                                    input int unsigned frac);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        s;
    logic [63:0]        g;
    logic signed [63:0] sum;
    int unsigned        kk;
    kk   = (k > PanSteps) ? PanSteps : k;
    x    = (PiQ30 * 64'(kk) + 64'd200) / 64'd400;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / SeriesDiv[n];
      if (n % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > OneQ30) begin
      sum = OneQ30;
    end
    s = unsigned'(sum);
    g = (s + (64'd1 << (29 - frac))) >> (30 - frac);
    if (g > (64'd1 << frac)) begin
      g = 64'd1 << frac;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

[src/constant_power_stereo_pan_core.sv]
// ----------------------------------------------------------------------------
// constant_power_stereo_pan_core
// equal-power stereo pan of an interleaved 16-bit sample stream
// ----------------------------------------------------------------------------
// usage:
//   samples enter on the s_axis channel (tdata: sample, channel index; tlast:
//   end of buffer) and leave on the m_axis channel (tdata: sample; tlast).
//   in stereo mode (channel count two) channel 0 is scaled by cos and channel
//   1 by sin of the pan angle; every other sample passes through unchanged.
//   pan and channel count are written over the apb port while the stream is
//   idle; a pan write loads both gains from a constant quarter-sine table in
//   the same cycle.
//   pipeline: three register stages (select, multiply, saturate);
//   m_axis_tvalid is the valid bit of the saturate stage register.
//   throughput: one sample per cycle while m_axis_tready stays high, set
//   by the single multiplier stage.
//   reset: pipeline empties, pan returns to centre, channel count to two.
//   when the receiver stalls, each stage holds its request and bubbles are
//   squeezed out, so s_axis_tready drops only once all three stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "constant_power_stereo_pan_core_assert.svh"

module constant_power_stereo_pan_core #(
  parameter int unsigned GAIN_FRAC_BITS = cpsp_pkg::GainFracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [15:0] sample_in, [18:16] channel_index
  input  wire logic        s_axis_tlast,   // buffer_last
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [15:0] sample_out
  output logic             m_axis_tlast    // last_out
);

  import cpsp_pkg::*;

  localparam int unsigned GW = GAIN_FRAC_BITS + 1;
  localparam int unsigned PW = 17 + GW;
  localparam int unsigned SW = PW - GAIN_FRAC_BITS;
  localparam logic [GW-1:0] CentreGain =
    GW'(cpsp_quarter_sine(PanSteps / 2, GAIN_FRAC_BITS));

  // ---------------------------------------------------------------- gain table
  logic [GW-1:0] gain_table [PanSteps+1];
  for (genvar gi = 0; gi <= PanSteps; gi++) begin : g_table
    localparam logic [GW-1:0] Entry = GW'(cpsp_quarter_sine(gi, GAIN_FRAC_BITS));
    assign gain_table[gi] = Entry;
  end

  // ---------------------------------------------------------------- config
  logic signed [7:0] pan_q, pan_d;
  logic        [3:0] chan_cnt_q, chan_cnt_d;
  logic     [GW-1:0] left_gain_q, left_gain_d;
  logic     [GW-1:0] right_gain_q, right_gain_d;
  logic              cfg_wr;
  cpsp_reg_e         reg_sel;
  logic signed [7:0] pan_wr;
  logic signed [7:0] pan_clamped;
  logic        [7:0] pan_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = cpsp_reg_e'(paddr[2]);
  assign pan_wr  = pwdata[7:0];

  always_comb begin
    priority if (pan_wr < -8'sd100) begin
      pan_clamped = -8'sd100;
    end else if (pan_wr > 8'sd100) begin
      pan_clamped = 8'sd100;
    end else begin
      pan_clamped = pan_wr;
    end
  end

  assign pan_idx = 8'(pan_clamped + 8'(PanOffset));

  always_comb begin
    pan_d        = pan_q;
    chan_cnt_d   = chan_cnt_q;
    left_gain_d  = left_gain_q;
    right_gain_d = right_gain_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        RegPan: begin
          pan_d        = pan_wr;
          right_gain_d = gain_table[pan_idx];
          left_gain_d  = gain_table[8'(PanSteps) - pan_idx];
        end
        RegChannels: begin
          chan_cnt_d = pwdata[3:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPan:      prdata = {{24{pan_q[7]}}, pan_q};
      RegChannels: prdata = {28'd0, chan_cnt_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q        <= 8'sd0;
      chan_cnt_q   <= 4'd2;
      left_gain_q  <= CentreGain;
      right_gain_q <= CentreGain;
    end else begin
      pan_q        <= pan_d;
      chan_cnt_q   <= chan_cnt_d;
      left_gain_q  <= left_gain_d;
      right_gain_q <= right_gain_d;
    end
  end

  // ---------------------------------------------------------------- pipeline
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 1: gain select and magnitude
  logic          neg1_q, pass1_q, last1_q;
  logic [16:0]   mag1_q;
  logic [GW-1:0] gain1_q;
  logic [15:0]   samp1_q;
  // stage 2: product
  logic          neg2_q, pass2_q, last2_q;
  logic [PW-1:0] prod2_q;
  logic [15:0]   samp2_q;
  // stage 3: output register
  logic [15:0]   out3_q;
  logic          last3_q;

  logic [15:0] in_samp;
  logic [2:0]  in_chan;
  logic        in_neg;
  logic [16:0] in_mag;
  logic        in_use_gain;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  assign in_samp     = s_axis_tdata[15:0];
  assign in_chan     = s_axis_tdata[18:16];
  assign in_neg      = in_samp[15];
  assign in_mag      = in_neg ? (17'd0 - {1'b1, in_samp}) : {1'b0, in_samp};
  assign in_use_gain = (chan_cnt_q == 4'd2) && (in_chan < 3'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      neg1_q  <= in_neg;
      mag1_q  <= in_mag;
      gain1_q <= (in_chan == 3'd0) ? left_gain_q : right_gain_q;
      pass1_q <= !in_use_gain;
      samp1_q <= in_samp;
      last1_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prod2_q <= PW'(mag1_q) * PW'(gain1_q);
      neg2_q  <= neg1_q;
      pass2_q <= pass1_q;
      samp2_q <= samp1_q;
      last2_q <= last1_q;
    end
  end

  logic [SW-1:0] shr;
  logic [SW-1:0] shr_neg;
  logic [15:0]   sat;

  assign shr     = prod2_q[PW-1:GAIN_FRAC_BITS];
  assign shr_neg = SW'(0) - shr;

  always_comb begin
    priority if (pass2_q) begin
      sat = samp2_q;
    end else if (neg2_q) begin
      sat = (shr > SW'(32768)) ? 16'h8000 : shr_neg[15:0];
    end else begin
      sat = (shr > SW'(32767)) ? 16'h7fff : shr[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      out3_q  <= sat;
      last3_q <= last2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out3_q;
  assign m_axis_tlast  = last3_q;

  // ---------------------------------------------------------------- checks
  `CPSP_ASSERT_SAME(a_no_overrun, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !v1_q || en2, "request accepted into a blocked stage")
  `CPSP_ASSERT_NEXT(a_prod_hold, clk_i, rst_ni, v2_q && !en3, v2_q && $stable(prod2_q), "stalled product lost")
  `CPSP_ASSERT_SAME(a_gain_limit, clk_i, rst_ni, 1'b1, (left_gain_q <= (GW'(1) << GAIN_FRAC_BITS)) && (right_gain_q <= (GW'(1) << GAIN_FRAC_BITS)), "gain above unity")

endmodule

`default_nettype wire

[verif/constant_power_stereo_pan_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_power_stereo_pan_core_tb
// streams directed and random interleaved samples through the pan core under
// several pan and channel-count settings and idle patterns; every output
// sample is compared against an in-bench equal-power gain predictor
// ----------------------------------------------------------------------------

module constant_power_stereo_pan_core_tb;
  import cpsp_pkg::*;

  localparam int unsigned FracBits       = GainFracBitsDefault;
  localparam logic [3:0]  StereoChannels = 4'd2;
  localparam logic [2:0]  LeftChannel    = 3'd0;
  localparam logic [2:0]  RightChannel   = 3'd1;
  localparam int          SettleCycles   = 6;
  localparam int          SamplesPerCount = 30;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } pan_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [15:0] sample_in, [18:16] channel_index
  logic        s_axis_tlast  = 1'b0;  // buffer_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // [15:0] sample_out
  logic        m_axis_tlast;  // last_out

  pan_result_t pending_samples[$];
  pan_result_t got_sample;
  pan_result_t want_sample;
  int          fail_count     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  // predictor state
  int          pan_setting;
  logic [3:0]  chan_setting;
  logic [16:0] left_gain;
  logic [16:0] right_gain;

  constant_power_stereo_pan_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // sin(step*pi/400) in Q1.FracBits, series evaluated in Q2.30
  function automatic logic [16:0] sine_gain(input int unsigned step);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    int unsigned     kk;
    kk       = (step > PanSteps) ? PanSteps : step;
    angle    = (longint'(PiQ30) * kk + 200) / 400;
    angle_sq = (angle * angle + (64'd1 << 29)) >> 30;
    term     = angle;
    acc      = longint'(angle);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * angle_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > OneQ30) acc = OneQ30;
    rounded = (longint'(acc) + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
    if (rounded > (64'd1 << FracBits)) rounded = 64'd1 << FracBits;
    return rounded[16:0];
  endfunction

  function automatic void load_gains();
    int p;
    p          = pan_setting;
    if (p < -PanOffset) p = -PanOffset;
    if (p > PanOffset) p = PanOffset;
    right_gain = sine_gain(p + PanOffset);
    left_gain  = sine_gain(PanSteps - (p + PanOffset));
  endfunction

  // magnitude times gain, truncated toward zero, then saturated
  function automatic logic [15:0] scale_sample(input logic [15:0] smp,
                                               input logic [16:0] gain);
    longint value;
    longint mag;
    value = longint'(signed'(smp));
    mag   = (value < 0) ? -value : value;
    mag   = (mag * longint'(gain)) >>> FracBits;
    value = (value < 0) ? -mag : mag;
    if (value > 32767) value = 32767;
    if (value < -32768) value = -32768;
    return value[15:0];
  endfunction

  function automatic logic [15:0] panned_sample(input logic [15:0] smp,
                                                input logic [2:0] ch);
    if (chan_setting == StereoChannels && ch == LeftChannel) return scale_sample(smp, left_gain);
    if (chan_setting == StereoChannels && ch == RightChannel) return scale_sample(smp, right_gain);
    return smp;
  endfunction

  // receiver side backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_sample = '{sample: m_axis_tdata, last: m_axis_tlast};
      if (pending_samples.size() == 0) begin
        $error("unexpected output sample %h last %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want_sample = pending_samples.pop_front();
        if (got_sample.sample !== want_sample.sample) begin
          $error("sample_out expected %h actual %h", want_sample.sample, got_sample.sample);
          fail_count++;
        end
        if (got_sample.last !== want_sample.last) begin
          $error("last_out expected %b actual %b", want_sample.last, got_sample.last);
          fail_count++;
        end
      end
    end
  end

  task automatic set_idle_phase(input int phase);
    case (phase % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 51;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 51;
      end
      default: begin
        send_idle_pct  = 36;
        recv_stall_pct = 36;
      end
    endcase
  endtask

  // drop valid and let the pipeline empty before touching registers
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cpsp_reg_e which, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (which)
      RegPan: begin
        pan_setting = int'(signed'(value[7:0]));
        load_gains();
      end
      RegChannels: chan_setting = value[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper pwdata bits carry junk, only the register width counts
  task automatic set_pan(input int pan);
    logic [31:0] word;
    word      = $urandom();
    word[7:0] = pan[7:0];
    settle();
    write_reg(RegPan, word);
  endtask

  task automatic set_channels(input int count);
    logic [31:0] word;
    word      = $urandom();
    word[3:0] = count[3:0];
    settle();
    write_reg(RegChannels, word);
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic [2:0] ch, input logic lst);
    pan_result_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, ch, smp};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    want = '{sample: panned_sample(smp, ch), last: lst};
    pending_samples = {pending_samples, want};
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(15)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  // frames of interleaved channels, tlast on the final sample, some stray indexes
  task automatic send_buffer(input int frames, input int width);
    logic [2:0] ch;
    for (int f = 0; f < frames; f++) begin
      for (int c = 0; c < width; c++) begin
        ch = 3'(c);
        if ($urandom_range(19) == 0) ch = 3'($urandom_range(7));
        send_sample(random_sample(), ch, (f == frames - 1) && (c == width - 1));
      end
    end
  endtask

  task automatic test_directed();
    logic [15:0] corners[5];
    corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    set_idle_phase(0);
    // reset gains, centre pan in stereo
    for (int i = 0; i < 5; i++) begin
      send_sample(corners[i], LeftChannel, i[0]);
      send_sample(corners[i], RightChannel, ~i[0]);
    end
    // stereo samples on channels beyond the pair pass straight through
    for (int c = 2; c < 8; c++) send_sample(corners[c % 5], 3'(c), 1'b0);
    // pan beyond range clamps to the ends
    set_pan(127);
    send_sample(16'h7FFF, LeftChannel, 1'b0);
    send_sample(16'h8000, RightChannel, 1'b1);
    set_pan(-128);
    send_sample(16'h8000, LeftChannel, 1'b0);
    send_sample(16'h7FFF, RightChannel, 1'b1);
    // counts of zero and above the channel limit mean pass-through
    set_channels(0);
    send_sample(16'h8000, LeftChannel, 1'b0);
    send_sample(16'h7FFF, RightChannel, 1'b1);
    set_channels(15);
    send_sample(16'h7FFF, LeftChannel, 1'b0);
    send_sample(16'h8000, RightChannel, 1'b1);
  endtask

  task automatic test_stereo_pan();
    int pans[14];
    pans = '{0, -100, 100, -101, 101, -128, 127, -50, 50, 0, 0, 0, 0, 0};
    for (int i = 9; i < 14; i++) pans[i] = int'(signed'(8'($urandom())));
    set_channels(StereoChannels);
    for (int i = 0; i < 14; i++) begin
      set_pan(pans[i]);
      set_idle_phase(i);
      repeat (4) send_buffer($urandom_range(1, 10), 2);
    end
  endtask

  task automatic test_other_counts();
    int counts[10];
    int width;
    int frames;
    int sent;
    counts = '{1, 3, 4, 5, 6, 7, 8, 0, 15, 9};
    set_pan(int'(signed'(8'($urandom()))));
    for (int i = 0; i < 10; i++) begin
      set_channels(counts[i]);
      set_idle_phase(i + 1);
      width = (counts[i] >= 1 && counts[i] <= 8) ? counts[i] : 8;
      sent  = 0;
      while (sent < SamplesPerCount) begin
        frames = $urandom_range(1, 4);
        send_buffer(frames, width);
        sent += frames * width;
      end
    end
    set_channels(StereoChannels);
  endtask

  initial begin
    pan_setting  = 0;
    chan_setting = StereoChannels;
    load_gains();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_stereo_pan();
    test_other_counts();
    settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/cpsp_pkg.sv
src/constant_power_stereo_pan_core.sv
verif/constant_power_stereo_pan_core_tb.sv
